FILE: rtl/core/assert_macros.svh
// Assertion macros used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/psched_pkg.sv
// Shared constants and types of the preemptive priority scheduler.
package psched_pkg;

   localparam int FIELD_W   = 16;
   localparam int TIME_W    = 24;
   localparam int JOB_OUT_W = 5;

   // Request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Best ready job seen so far, handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] prio;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] burst;
      logic               last;    // one tick of work left
   } cand_type;

   // Per-cell controls from the sequencer
   typedef struct packed {
      logic load;     // write the loaded job into this cell
      logic dec;      // this cell's job ran this tick
      logic active;   // slot holds a loaded job
   } cell_ctl_type;

endpackage

FILE: rtl/core/psched_req_if.sv
// Request channel: job loads and scheduler ticks.
interface psched_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [psched_pkg::FIELD_W-1:0] job_priority;
   logic [psched_pkg::FIELD_W-1:0] arrival_time;
   logic [psched_pkg::FIELD_W-1:0] burst_length;

   modport source (output valid, op, job_priority, arrival_time, burst_length,
                   input ready);
   modport sink   (input valid, op, job_priority, arrival_time, burst_length,
                   output ready);
endinterface

FILE: rtl/core/psched_rsp_if.sv
// Response channel: one report per scheduler tick.
interface psched_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [psched_pkg::JOB_OUT_W-1:0] running_job;
   logic                             idle;
   logic                             switched;
   logic                             finished;
   logic [psched_pkg::TIME_W-1:0]    finish_time;
   logic [psched_pkg::TIME_W-1:0]    turnaround;
   logic [psched_pkg::TIME_W-1:0]    waiting;
   logic                             all_done;

   modport source (output valid, running_job, idle, switched, finished, finish_time,
                   turnaround, waiting, all_done,
                   input ready);
   modport sink   (input valid, running_job, idle, switched, finished, finish_time,
                   turnaround, waiting, all_done,
                   output ready);
endinterface

FILE: rtl/core/psched_cell.sv
// One job slot of the scheduler chain: job storage plus one compare stage.
module psched_cell #(
   parameter int IDX_W = 4
) (
   input  logic                             clock,
   input  psched_pkg::cell_ctl_type         ctl,
   input  logic [psched_pkg::FIELD_W-1:0]   load_priority,
   input  logic [psched_pkg::FIELD_W-1:0]   load_arrival,
   input  logic [psched_pkg::FIELD_W-1:0]   load_burst,
   input  logic [psched_pkg::TIME_W-1:0]    current_time,
   input  logic [IDX_W-1:0]                 cell_index,
   input  psched_pkg::cand_type             cand_in,
   input  logic [IDX_W-1:0]                 idx_in,
   output psched_pkg::cand_type             cand_out,
   output logic [IDX_W-1:0]                 idx_out
);

   logic [psched_pkg::FIELD_W-1:0] priority_ff;
   logic [psched_pkg::FIELD_W-1:0] arrival_ff;
   logic [psched_pkg::FIELD_W-1:0] burst_ff;
   logic [psched_pkg::FIELD_W-1:0] remaining_ff;
   psched_pkg::cand_type           cand_ff;
   psched_pkg::cand_type           cand_in_mine;
   logic [IDX_W-1:0]               idx_ff;
   logic                           ready;
   logic                           better;

   // Job storage: written on load, counted down when the job runs
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         priority_ff  <= load_priority;
         arrival_ff   <= load_arrival;
         burst_ff     <= load_burst;
         remaining_ff <= load_burst;
      end else if (ctl.dec) begin
         remaining_ff <= remaining_ff - psched_pkg::FIELD_W'(1);
      end
   end

   // Ready: loaded, work left, already arrived
   assign ready = ctl.active && (remaining_ff != '0) &&
                  ({(psched_pkg::TIME_W - psched_pkg::FIELD_W)'(0), arrival_ff}
                   <= current_time);

   // Strictly better only; on a full tie the lower slot upstream keeps it
   assign better = ready && (!cand_in.valid ||
                             (priority_ff < cand_in.prio) ||
                             ((priority_ff == cand_in.prio) &&
                              (arrival_ff < cand_in.arrival)));

   always_comb begin
      cand_in_mine.valid   = 1'b1;
      cand_in_mine.prio    = priority_ff;
      cand_in_mine.arrival = arrival_ff;
      cand_in_mine.burst   = burst_ff;
      cand_in_mine.last    = (remaining_ff == psched_pkg::FIELD_W'(1));
   end

   // Compare stage toward the next cell
   always_ff @(posedge clock) begin
      if (better) begin
         cand_ff <= cand_in_mine;
         idx_ff  <= cell_index;
      end else begin
         cand_ff <= cand_in;
         idx_ff  <= idx_in;
      end
   end

   assign cand_out = cand_ff;
   assign idx_out  = idx_ff;

endmodule

FILE: rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: chain of job cells plus tick sequencer.
//
//   channel   dir   payload                                          transfer
//   req_chan  in    op, job_priority, arrival_time, burst_length     valid & ready
//   rsp_chan  out   running_job, idle, switched, finished,           valid & ready
//                   finish_time, turnaround, waiting, all_done
//
// A load gives no response.
// In a tick the best-job candidate walks the cell chain one cell per cycle in
// ST_SCAN, then ST_UPDATE updates the job and ST_RESULT builds the response.
// Reset (synchronous) empties the table and zeroes time; job slots keep no reset.
// The response sits in an output register; a new request is taken while it waits,
// and a finished tick holds in its last step until that register is free.
`include "assert_macros.svh"

module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input logic               clock,
   input logic               reset,
   psched_req_if.sink        req_chan,
   psched_rsp_if.source      rsp_chan
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = psched_pkg::TIME_W;
   localparam int FW    = psched_pkg::FIELD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  scan_cnt_ff;
   logic [CNT_W-1:0]  job_count_ff;
   logic [CNT_W-1:0]  done_count_ff;
   logic [TW-1:0]     time_ff;
   logic [CNT_W-1:0]  last_job_ff;

   // Tick result held between update and response
   logic [CNT_W-1:0]  res_job_ff;
   logic              res_idle_ff;
   logic              res_sw_ff;
   logic              res_fin_ff;
   logic [TW-1:0]     res_time_ff;
   logic [TW-1:0]     res_tat_ff;
   logic [FW-1:0]     res_burst_ff;

   // Response register
   logic                             rsp_valid_ff;
   logic [psched_pkg::JOB_OUT_W-1:0] rsp_job_ff;
   logic                             rsp_idle_ff;
   logic                             rsp_sw_ff;
   logic                             rsp_fin_ff;
   logic [TW-1:0]                    rsp_time_ff;
   logic [TW-1:0]                    rsp_tat_ff;
   logic [TW-1:0]                    rsp_wait_ff;
   logic                             rsp_done_ff;

   psched_pkg::cand_type     cand_chain [MAX_PROCS+1];
   logic [IDX_W-1:0]         idx_chain  [MAX_PROCS+1];
   psched_pkg::cell_ctl_type cell_ctl   [MAX_PROCS];

   logic                 req_accept;
   logic                 load_ok;
   psched_pkg::cand_type best;
   logic [IDX_W-1:0]     best_idx;
   logic [CNT_W-1:0]     job_in;
   logic [TW-1:0]        fin_in;
   logic                 rsp_free;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign load_ok    = (job_count_ff < CNT_W'(MAX_PROCS));
   assign best       = cand_chain[MAX_PROCS];
   assign best_idx   = idx_chain[MAX_PROCS];
   assign job_in     = best.valid ? (CNT_W'(best_idx) + CNT_W'(1)) : '0;
   assign fin_in     = time_ff + TW'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // Head of the chain: no candidate yet
   assign cand_chain[0] = '0;
   assign idx_chain[0]  = '0;

   // Cell chain
   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].load   = req_accept && (req_chan.op == psched_pkg::OP_LOAD) &&
                              load_ok && (job_count_ff == CNT_W'(i));
         cell_ctl[i].dec    = (state_ff == ST_UPDATE) && best.valid &&
                              (best_idx == IDX_W'(i));
         cell_ctl[i].active = (CNT_W'(i) < job_count_ff);
      end

      psched_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock         (clock),
         .ctl           (cell_ctl[i]),
         .load_priority (req_chan.job_priority),
         .load_arrival  (req_chan.arrival_time),
         .load_burst    (req_chan.burst_length),
         .current_time  (time_ff),
         .cell_index    (IDX_W'(i)),
         .cand_in       (cand_chain[i]),
         .idx_in        (idx_chain[i]),
         .cand_out      (cand_chain[i+1]),
         .idx_out       (idx_chain[i+1])
      );
   end

   // Sequencer, scheduler state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_cnt_ff   <= '0;
         job_count_ff  <= '0;
         done_count_ff <= '0;
         time_ff       <= '0;
         last_job_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_chan.op == psched_pkg::OP_TICK) begin
                     state_ff    <= ST_SCAN;
                     scan_cnt_ff <= '0;
                  end else if (load_ok) begin
                     job_count_ff <= job_count_ff + CNT_W'(1);
                     // zero burst counts as done at once
                     if (req_chan.burst_length == '0) begin
                        done_count_ff <= done_count_ff + CNT_W'(1);
                     end
                  end
               end
            end

            // Let the candidate settle through every cell
            ST_SCAN: begin
               scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
               if (scan_cnt_ff == IDX_W'(MAX_PROCS - 1)) begin
                  state_ff <= ST_UPDATE;
               end
            end

            ST_UPDATE: begin
               res_job_ff   <= job_in;
               res_idle_ff  <= !best.valid;
               res_sw_ff    <= (job_in != last_job_ff);
               res_fin_ff   <= best.valid && best.last;
               res_time_ff  <= fin_in;
               res_burst_ff <= best.burst;
               if (best.valid && best.last) begin
                  res_tat_ff    <= fin_in - {(TW - FW)'(0), best.arrival};
                  done_count_ff <= done_count_ff + CNT_W'(1);
               end else begin
                  res_tat_ff <= '0;
               end
               last_job_ff <= job_in;
               time_ff     <= fin_in;
               state_ff    <= ST_RESULT;
            end

            ST_RESULT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_job_ff   <= psched_pkg::JOB_OUT_W'(res_job_ff);
                  rsp_idle_ff  <= res_idle_ff;
                  rsp_sw_ff    <= res_sw_ff;
                  rsp_fin_ff   <= res_fin_ff;
                  rsp_time_ff  <= res_time_ff;
                  rsp_tat_ff   <= res_tat_ff;
                  rsp_wait_ff  <= res_fin_ff ?
                                  (res_tat_ff - {(TW - FW)'(0), res_burst_ff}) : '0;
                  rsp_done_ff  <= (done_count_ff == job_count_ff);
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Port drive
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.running_job = rsp_job_ff;
   assign rsp_chan.idle        = rsp_idle_ff;
   assign rsp_chan.switched    = rsp_sw_ff;
   assign rsp_chan.finished    = rsp_fin_ff;
   assign rsp_chan.finish_time = rsp_time_ff;
   assign rsp_chan.turnaround  = rsp_tat_ff;
   assign rsp_chan.waiting     = rsp_wait_ff;
   assign rsp_chan.all_done    = rsp_done_ff;

   // Checks
   `ASSERT_IMPLY(a_done_le_jobs, clock, reset, 1'b1, done_count_ff <= job_count_ff, "more jobs done than loaded")
   `ASSERT_NEXT(a_time_only_on_update, clock, reset, !reset && (state_ff != ST_UPDATE), $stable(time_ff), "time moved outside a tick update")
   `ASSERT_IMPLY(a_idle_report, clock, reset, rsp_valid_ff && rsp_idle_ff, (rsp_job_ff == '0) && !rsp_fin_ff, "idle tick reports a job")

endmodule

FILE: dv/preemptive_priority_scheduler_checker.sv
// Scoreboard for the preemptive priority scheduler: predicts tick reports and compares.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_checker #(
   parameter int JOB_SLOTS = 16
) (
   input  logic  clock,
   input  logic  reset,
   psched_req_if req_chan,
   psched_rsp_if rsp_chan,
   output int    mismatches,
   output int    outstanding
);

   typedef struct packed {
      logic [psched_pkg::JOB_OUT_W-1:0] running_job;
      logic                             idle;
      logic                             switched;
      logic                             finished;
      logic [psched_pkg::TIME_W-1:0]    finish_time;
      logic [psched_pkg::TIME_W-1:0]    turnaround;
      logic [psched_pkg::TIME_W-1:0]    waiting;
      logic                             all_done;
   } sched_report_type;

   // Shadow copy of the job table and scheduler clock
   logic [psched_pkg::FIELD_W-1:0]   job_prio    [JOB_SLOTS];
   logic [psched_pkg::FIELD_W-1:0]   job_arrival [JOB_SLOTS];
   logic [psched_pkg::FIELD_W-1:0]   job_burst   [JOB_SLOTS];
   logic [psched_pkg::FIELD_W-1:0]   work_left   [JOB_SLOTS];
   int                               job_count;
   int                               done_count;
   logic [psched_pkg::TIME_W-1:0]    sched_time;
   logic [psched_pkg::JOB_OUT_W-1:0] prev_job;

   sched_report_type expected_reports [$];
   int               report_seq;

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("report %0d %s: got %0d, expected %0d",
                                   report_seq, name, got, want));
   endtask

   // Loads into a full table are dropped; a zero burst counts as done at once
   function automatic void load_job(logic [psched_pkg::FIELD_W-1:0] prio,
                                    logic [psched_pkg::FIELD_W-1:0] arrival,
                                    logic [psched_pkg::FIELD_W-1:0] burst);
      if (job_count < JOB_SLOTS) begin
         job_prio[job_count]    = prio;
         job_arrival[job_count] = arrival;
         job_burst[job_count]   = burst;
         work_left[job_count]   = burst;
         if (burst == 0)
            done_count++;
         job_count++;
      end
   endfunction

   // One tick: pick the best ready job, run it once, build the report
   function automatic sched_report_type run_tick();
      sched_report_type              r;
      int                            pick;
      logic [psched_pkg::TIME_W-1:0] end_time;
      r    = '0;
      pick = -1;
      for (int s = 0; s < job_count; s++) begin
         if (work_left[s] != 0 && psched_pkg::TIME_W'(job_arrival[s]) <= sched_time) begin
            // lowest priority value, then earliest arrival, then lowest slot
            if (pick < 0 || job_prio[s] < job_prio[pick] ||
                (job_prio[s] == job_prio[pick] && job_arrival[s] < job_arrival[pick]))
               pick = s;
         end
      end
      end_time      = sched_time + psched_pkg::TIME_W'(1);
      r.finish_time = end_time;
      r.idle        = (pick < 0);
      if (pick >= 0) begin
         r.running_job = psched_pkg::JOB_OUT_W'(pick + 1);
         work_left[pick]--;
         if (work_left[pick] == 0) begin
            r.finished   = 1'b1;
            done_count++;
            r.turnaround = end_time - psched_pkg::TIME_W'(job_arrival[pick]);
            r.waiting    = r.turnaround - psched_pkg::TIME_W'(job_burst[pick]);
         end
      end
      r.switched = (r.running_job != prev_job);
      prev_job   = r.running_job;
      sched_time = end_time;
      r.all_done = (done_count == job_count);
      return r;
   endfunction

   // Reports are checked before the same edge's request is predicted
   always @(posedge clock) begin
      sched_report_type want;
      if (reset) begin
         job_count  = 0;
         done_count = 0;
         sched_time = '0;
         prev_job   = '0;
         report_seq = 0;
         expected_reports.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("report %0d arrived with no tick pending",
                                         report_seq));
            end else begin
               want = expected_reports.pop_front();
               check_field("running_job", 32'(rsp_chan.running_job), 32'(want.running_job));
               check_field("idle",        32'(rsp_chan.idle),        32'(want.idle));
               check_field("switched",    32'(rsp_chan.switched),    32'(want.switched));
               check_field("finished",    32'(rsp_chan.finished),    32'(want.finished));
               check_field("finish_time", 32'(rsp_chan.finish_time), 32'(want.finish_time));
               check_field("turnaround",  32'(rsp_chan.turnaround),  32'(want.turnaround));
               check_field("waiting",     32'(rsp_chan.waiting),     32'(want.waiting));
               check_field("all_done",    32'(rsp_chan.all_done),    32'(want.all_done));
            end
            report_seq++;
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.op == psched_pkg::OP_TICK)
               expected_reports.push_back(run_tick());
            else
               load_job(req_chan.job_priority, req_chan.arrival_time,
                        req_chan.burst_length);
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

FILE: dv/preemptive_priority_scheduler_test.sv
// Testbench top: drives job loads and ticks into the scheduler and gives the verdict.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_test;

   localparam int JOB_SLOTS    = 16;
   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_ITEMS = 730;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * (JOB_SLOTS + 3);

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int loads_sent    = 0;
   int ticks_sent    = 0;
   int mismatches;
   int outstanding;

   psched_req_if req_chan ();
   psched_rsp_if rsp_chan ();

   preemptive_priority_scheduler #(
      .MAX_PROCS (JOB_SLOTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   preemptive_priority_scheduler_checker #(
      .JOB_SLOTS (JOB_SLOTS)
   ) scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #HALF_PERIOD clock = ~clock;

   // Response sink: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         holds_served   <= 0;
      end else if (hold_requests != holds_served) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= LONG_HOLD;
         holds_served   <= holds_served + 1;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[preemptive_priority_scheduler] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request and hold it until the transfer; valid stays up afterwards
   task automatic send_item(input logic op, input logic [psched_pkg::FIELD_W-1:0] prio,
                            input logic [psched_pkg::FIELD_W-1:0] arrival,
                            input logic [psched_pkg::FIELD_W-1:0] burst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.job_priority <= prio;
      req_chan.arrival_time <= arrival;
      req_chan.burst_length <= burst;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (op == psched_pkg::OP_TICK)
         ticks_sent++;
      else
         loads_sent++;
   endtask

   // Tick payload is don't-care, so it carries random noise
   task automatic send_tick();
      send_item(psched_pkg::OP_TICK, psched_pkg::FIELD_W'($urandom_range(65535)),
                psched_pkg::FIELD_W'($urandom_range(65535)),
                psched_pkg::FIELD_W'($urandom_range(65535)));
   endtask

   // Drop valid and wait until every tick report has been taken
   task automatic wait_all_reported();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [psched_pkg::FIELD_W-1:0] prio;
      logic [psched_pkg::FIELD_W-1:0] arrival;
      logic [psched_pkg::FIELD_W-1:0] burst;
      int                             roll;
      int                             back;

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.op           = psched_pkg::OP_LOAD;
      req_chan.job_priority = '0;
      req_chan.arrival_time = '0;
      req_chan.burst_length = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, zero burst, later load that overtakes an earlier job, tie breaks
      send_tick();
      send_item(psched_pkg::OP_LOAD, 16'd0, 16'd0, 16'd0);
      send_tick();
      send_item(psched_pkg::OP_LOAD, 16'd5, 16'd3, 16'd2);
      send_tick();
      send_tick();
      send_item(psched_pkg::OP_LOAD, 16'd2, 16'd1, 16'd3);
      repeat (4) send_tick();
      send_item(psched_pkg::OP_LOAD, 16'd4, 16'd9, 16'd2);
      send_item(psched_pkg::OP_LOAD, 16'd4, 16'd8, 16'd2);
      send_item(psched_pkg::OP_LOAD, 16'd4, 16'd8, 16'd1);
      repeat (6) send_tick();
      // all-ones job: arrives far beyond this run, never gets to run
      send_item(psched_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick();

      // Random: mostly ticks, loads spread out until the table is full
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n * 4 / RANDOM_ITEMS)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         if (n == 100)
            hold_requests <= hold_requests + 1;
         if (n == 400)
            wait_all_reported();

         // loads into a full table are ignored and only add noise
         if (loads_sent >= JOB_SLOTS && $urandom_range(99) < 5)
            send_item(psched_pkg::OP_LOAD, psched_pkg::FIELD_W'($urandom_range(65535)),
                      psched_pkg::FIELD_W'($urandom_range(65535)),
                      psched_pkg::FIELD_W'($urandom_range(65535)));

         if (loads_sent < JOB_SLOTS && ($urandom_range(49) == 0 || n >= 560)) begin
            roll = $urandom_range(99);
            prio = (roll < 20) ? psched_pkg::FIELD_W'($urandom_range(65535)) :
                                 psched_pkg::FIELD_W'($urandom_range(7));
            roll = $urandom_range(99);
            back = $urandom_range(10);
            if (roll < 70)
               arrival = psched_pkg::FIELD_W'(ticks_sent + $urandom_range(20));
            else if (roll < 90)
               arrival = (ticks_sent > back) ? psched_pkg::FIELD_W'(ticks_sent - back) : '0;
            else
               arrival = psched_pkg::FIELD_W'($urandom_range(65535));
            burst = ($urandom_range(99) < 3) ? '0 : psched_pkg::FIELD_W'($urandom_range(1, 30));
            send_item(psched_pkg::OP_LOAD, prio, arrival, burst);
         end else begin
            send_tick();
         end
      end

      wait_all_reported();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[preemptive_priority_scheduler] OK");
      else
         $display("[preemptive_priority_scheduler] ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/psched_pkg.sv
rtl/core/psched_req_if.sv
rtl/core/psched_rsp_if.sv
rtl/core/psched_cell.sv
rtl/core/preemptive_priority_scheduler.sv
dv/preemptive_priority_scheduler_checker.sv
dv/preemptive_priority_scheduler_test.sv
